// File: sv/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// types, job codes and constant tables for the dh forward kinematics unit
// ----------------------------------------------------------------------------
`default_nettype none

package dhfk_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANGLE_BITS_DEF   = 16;

	localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
	localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;

	// job codes of the shared multiplier
	localparam logic [4:0] JOB_ST_CA = 5'd0;
	localparam logic [4:0] JOB_ST_SA = 5'd1;
	localparam logic [4:0] JOB_CT_CA = 5'd2;
	localparam logic [4:0] JOB_CT_SA = 5'd3;
	localparam logic [4:0] JOB_A_CT  = 5'd4;
	localparam logic [4:0] JOB_A_ST  = 5'd5;
	localparam logic [4:0] JOB_MAT0  = 5'd6;
	localparam logic [4:0] JOB_LAST  = 5'd17;

	typedef struct packed {
		logic signed [31:0] link_length;
		logic        [15:0] link_twist;
		logic signed [31:0] link_offset;
		logic        [15:0] joint_zero;
		logic        [15:0] joint_angle;
		logic               last_joint;
	} joint_t;

	typedef struct packed {
		logic signed [31:0] rot_00;
		logic signed [31:0] rot_01;
		logic signed [31:0] rot_02;
		logic signed [31:0] rot_10;
		logic signed [31:0] rot_11;
		logic signed [31:0] rot_12;
		logic signed [31:0] rot_20;
		logic signed [31:0] rot_21;
		logic signed [31:0] rot_22;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pose_t;

	// arctangent table, 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051D;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2F9;
			5'd15:   r = 32'h0000517C;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A2F;
			5'd19:   r = 32'h00000517;
			5'd20:   r = 32'h0000028B;
			5'd21:   r = 32'h00000145;
			5'd22:   r = 32'h000000A2;
			5'd23:   r = 32'h00000051;
			5'd24:   r = 32'h00000028;
			5'd25:   r = 32'h00000014;
			5'd26:   r = 32'h0000000A;
			5'd27:   r = 32'h00000005;
			5'd28:   r = 32'h00000002;
			5'd29:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [31:0] r;
		if (v > 37'sh7FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -37'sh80000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd1073741824) begin
			r = ONE_Q30;
		end else if (v < -36'sd1073741824) begin
			r = -ONE_Q30;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/dh_forward_kinematics_chain_unit.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_unit
// serial dh chain: cordic sine/cosine and a bit-serial multiply-accumulate
// ----------------------------------------------------------------------------
// One joint transaction at a time. Each joint runs two cordic passes, then
// 42 products on one shift-add multiplier retiring one multiplier bit per
// cycle, each product after an operand load, then one write-back per job and
// a commit. A pose transaction is produced on the joint marked last; while an
// earlier pose still waits in the output register the next joint is already
// taken, and its commit holds only if a new pose would find that register
// still full.
// ----------------------------------------------------------------------------
`default_nettype none

module dh_forward_kinematics_chain_unit #(
	parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_BITS   = dhfk_pkg::ANGLE_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              joint_valid,
	output logic             joint_stall,
	input  dhfk_pkg::joint_t joint,
	output logic             pose_valid,
	input  wire              pose_stall,
	output dhfk_pkg::pose_t  pose
);
	import dhfk_pkg::*;

	localparam int CSTEPS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
	localparam int MUL_BITS = 32;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CORDIC = 6'b000010,
		S_LOAD   = 6'b000100,
		S_MUL    = 6'b001000,
		S_WB     = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0]        theta_q;
	logic signed [31:0] a_q;
	logic               last_q;
	logic               sel_q;
	logic               flip_q;
	logic [4:0]         step_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [31:0] sa_q, ca_q, st_q, ct_q;

	logic signed [31:0] rot_q [9];
	logic signed [31:0] tr_q  [3];
	logic signed [31:0] nr_q  [9];
	logic signed [31:0] nt_q  [3];
	logic signed [31:0] jr_q  [9];
	logic signed [31:0] jt_q  [3];

	logic [4:0]         job_q;
	logic [1:0]         term_q;
	logic [4:0]         bit_q;
	logic signed [31:0] m_q;
	logic [31:0]        lo_q;
	logic signed [32:0] hi_q;
	logic signed [65:0] sum_q;

	logic               out_valid_q;
	pose_t              out_q;

	wire joint_acc = joint_valid && !joint_stall;
	wire pose_acc  = out_valid_q && !pose_stall;

	assign joint_stall = (state_q != S_IDLE);
	assign pose_valid  = out_valid_q;
	assign pose        = out_q;

	// cordic start values
	logic [15:0]        init_ang;
	logic [23:0]        ang24;
	logic [31:0]        ang32;
	logic               init_flip;
	logic signed [33:0] init_z;

	always_comb begin
		init_ang  = joint_acc ? joint.link_twist : theta_q;
		ang24     = {init_ang, 8'h00};
		ang32     = {ang24[23 -: ANGLE_BITS], {(32 - ANGLE_BITS){1'b0}}};
		init_flip = ang32[31] ^ ang32[30];
		init_z    = 34'(signed'({ang32[31] ^ init_flip, ang32[30:0]}));
	end

	// one cordic iteration
	logic signed [33:0] xs, ys, at, x_n, y_n, z_n, xf, yf;
	logic               last_step;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = 34'(atan_turn(step_q));
		if (!z_q[33]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - at;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + at;
		end
		xf = flip_q ? -x_n : x_n;
		yf = flip_q ? -y_n : y_n;
		last_step = (step_q == 5'(CSTEPS - 1));
	end

	logic signed [31:0] cos_v, sin_v;
	assign cos_v = clamp_q30(36'(xf));
	assign sin_v = clamp_q30(36'(yf));

	// operand selection
	logic [3:0]         j6;
	logic [1:0]         row, col;
	logic [3:0]         ridx, jidx;
	logic signed [31:0] op_m, op_b;
	logic               single;

	always_comb begin
		j6     = 4'(job_q - JOB_MAT0);
		row    = j6[3:2];
		col    = j6[1:0];
		ridx   = 4'(row * 3 + term_q);
		jidx   = 4'(term_q * 3 + col);
		single = (job_q < JOB_MAT0);
		op_m   = rot_q[ridx];
		op_b   = (col == 2'd3) ? jt_q[term_q] : jr_q[jidx];
		unique case (job_q)
			JOB_ST_CA: begin op_m = st_q; op_b = ca_q; end
			JOB_ST_SA: begin op_m = st_q; op_b = sa_q; end
			JOB_CT_CA: begin op_m = ct_q; op_b = ca_q; end
			JOB_CT_SA: begin op_m = ct_q; op_b = sa_q; end
			JOB_A_CT:  begin op_m = a_q;  op_b = ct_q; end
			JOB_A_ST:  begin op_m = a_q;  op_b = st_q; end
			default: ;
		endcase
	end

	// shift-add step
	logic signed [33:0] madd, mstep;
	logic signed [64:0] prod;
	logic               last_bit;

	always_comb begin
		last_bit = (bit_q == 5'(MUL_BITS - 1));
		madd     = lo_q[0] ? (last_bit ? -34'(m_q) : 34'(m_q)) : 34'sd0;
		mstep    = 34'(hi_q) + madd;
		prod     = {mstep, lo_q[31:1]};
	end

	// rounding for write-back
	logic signed [65:0] sum_r;
	logic signed [35:0] rnd;
	logic signed [36:0] tsum;

	always_comb begin
		sum_r = sum_q + 66'sd536870912;
		rnd   = sum_r[65:30];
		tsum  = 37'(rnd) + 37'(tr_q[row]);
	end

	wire commit = (state_q == S_DONE) && (!last_q || !out_valid_q || !pose_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			step_q      <= '0;
			job_q       <= '0;
			term_q      <= '0;
			bit_q       <= '0;
			for (int k = 0; k < 9; k++) begin
				rot_q[k] <= (k % 4 == 0) ? ONE_Q30 : 32'sd0;
			end
			for (int k = 0; k < 3; k++) begin
				tr_q[k] <= 32'sd0;
			end
		end else begin
			if (pose_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (joint_acc) begin
						state_q <= S_CORDIC;
						sel_q   <= 1'b0;
						step_q  <= '0;
						x_q     <= CORDIC_K;
						y_q     <= 34'sd0;
						z_q     <= init_z;
						flip_q  <= init_flip;
					end
				end
				S_CORDIC: begin
					x_q    <= x_n;
					y_q    <= y_n;
					z_q    <= z_n;
					step_q <= step_q + 5'd1;
					if (last_step) begin
						step_q <= '0;
						x_q    <= CORDIC_K;
						y_q    <= 34'sd0;
						z_q    <= init_z;
						flip_q <= init_flip;
						sel_q  <= 1'b1;
						if (sel_q) begin
							state_q <= S_LOAD;
							job_q   <= '0;
							term_q  <= '0;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_MUL;
					bit_q   <= '0;
				end
				S_MUL: begin
					bit_q <= bit_q + 5'd1;
					if (last_bit) begin
						if (single || term_q == 2'd2) begin
							state_q <= S_WB;
						end else begin
							state_q <= S_LOAD;
							term_q  <= term_q + 2'd1;
						end
					end
				end
				S_WB: begin
					term_q <= '0;
					job_q  <= job_q + 5'd1;
					state_q <= (job_q == JOB_LAST) ? S_DONE : S_LOAD;
				end
				S_DONE: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (last_q) begin
							out_valid_q <= 1'b1;
							for (int k = 0; k < 9; k++) begin
								rot_q[k] <= (k % 4 == 0) ? ONE_Q30 : 32'sd0;
							end
							for (int k = 0; k < 3; k++) begin
								tr_q[k] <= 32'sd0;
							end
						end else begin
							for (int k = 0; k < 9; k++) begin
								rot_q[k] <= nr_q[k];
							end
							for (int k = 0; k < 3; k++) begin
								tr_q[k] <= nt_q[k];
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (joint_acc) begin
			theta_q  <= joint.joint_zero + joint.joint_angle;
			a_q      <= joint.link_length;
			last_q   <= joint.last_joint;
			jt_q[2]  <= joint.link_offset;
			jr_q[6]  <= 32'sd0;
			sum_q    <= 66'sd0;
		end
		if (state_q == S_CORDIC && last_step) begin
			if (sel_q) begin
				ct_q    <= cos_v;
				st_q    <= sin_v;
				jr_q[0] <= cos_v;
				jr_q[3] <= sin_v;
			end else begin
				ca_q    <= cos_v;
				sa_q    <= sin_v;
				jr_q[7] <= sin_v;
				jr_q[8] <= cos_v;
			end
		end
		if (state_q == S_LOAD) begin
			m_q  <= op_m;
			lo_q <= op_b;
			hi_q <= 33'sd0;
		end
		if (state_q == S_MUL) begin
			hi_q <= mstep[33:1];
			lo_q <= {mstep[0], lo_q[31:1]};
			if (last_bit) begin
				sum_q <= sum_q + 66'(prod);
			end
		end
		if (state_q == S_WB) begin
			sum_q <= 66'sd0;
			case (job_q)
				JOB_ST_CA: jr_q[1] <= -rnd[31:0];
				JOB_ST_SA: jr_q[2] <= rnd[31:0];
				JOB_CT_CA: jr_q[4] <= rnd[31:0];
				JOB_CT_SA: jr_q[5] <= -rnd[31:0];
				JOB_A_CT:  jt_q[0] <= sat32(37'(rnd));
				JOB_A_ST:  jt_q[1] <= sat32(37'(rnd));
				default: begin
					if (col == 2'd3) begin
						nt_q[row] <= sat32(tsum);
					end else begin
						nr_q[4'(row * 3 + col)] <= clamp_q30(rnd);
					end
				end
			endcase
		end
		if (commit && last_q) begin
			out_q <= '{nr_q[0], nr_q[1], nr_q[2], nr_q[3], nr_q[4], nr_q[5],
				nr_q[6], nr_q[7], nr_q[8], nt_q[0], nt_q[1], nt_q[2]};
		end
	end

	ap_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	ap_pose_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid) |-> $past(state_q == S_DONE && last_q))
		else $error("pose without a last joint");
	ap_wb_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> $past(state_q == S_MUL))
		else $error("write-back without a finished product");
	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pose_stall && state_q == S_DONE && last_q) |=> state_q == S_DONE)
		else $error("pending pose overwritten");

endmodule

`default_nettype wire
